/* design/fbdp_pkg.sv */
// Shared types and constants for the framebuffer dirty page engine.
// No dependencies; fbdp_alu and the engine unit import this package.
`default_nettype none

package fbdp_pkg;

    // Default geometry of the frame store.
    localparam int unsigned SCREEN_WIDTH_DEF  = 128;
    localparam int unsigned SCREEN_HEIGHT_DEF = 64;
    localparam int unsigned PAGE_COUNT_DEF    = 8;

    // Bits per stored byte, and so pixel rows per page.
    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned PAGE_BITS = 3;

    typedef logic [2:0] t_opcode;

    localparam t_opcode OP_PIXEL_WRITE  = 3'd0;
    localparam t_opcode OP_PIXEL_INVERT = 3'd1;
    localparam t_opcode OP_BYTE_COMBINE = 3'd2;
    localparam t_opcode OP_UPDATE       = 3'd3;
    localparam t_opcode OP_READ_BYTE    = 3'd4;
    localparam t_opcode OP_CLEAR        = 3'd5;

    typedef logic [2:0] t_mode;

    localparam t_mode CM_OR    = 3'd0;
    localparam t_mode CM_WRITE = 3'd1;
    localparam t_mode CM_AND   = 3'd2;
    localparam t_mode CM_XOR   = 3'd3;

    localparam logic [BYTE_BITS-1:0] ALL_PAGES = 8'hFF;

    // Controls handed from the sequencer to the byte combine unit.
    typedef struct packed {
        t_opcode               opcode;
        logic [PAGE_BITS-1:0]  bit_sel;
        logic                  pixel_on;
        logic [BYTE_BITS-1:0]  byte_value;
        t_mode                 mode;
    } t_alu_ctl;

endpackage

`default_nettype wire

/* design/fbdp_if.sv */
// Request and response channel interfaces of the framebuffer dirty page engine.
// Valid/ready handshake; a request moves when both are high at a clock edge.
`default_nettype none

interface fbdp_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic       pixel_on;
    logic [7:0] column;
    logic [7:0] page_index;
    logic [7:0] byte_value;
    logic [2:0] combine_mode;
    logic       link_busy;

    modport source (
        output valid, opcode, pos_x, pos_y, pixel_on, column, page_index,
               byte_value, combine_mode, link_busy,
        input  ready
    );
    modport sink (
        input  valid, opcode, pos_x, pos_y, pixel_on, column, page_index,
               byte_value, combine_mode, link_busy,
        output ready
    );
endinterface

interface fbdp_rsp_if;
    logic       valid;
    logic       ready;
    logic       send_valid;
    logic [2:0] send_page;
    logic [7:0] read_byte;
    logic [7:0] dirty_mask;

    modport source (
        output valid, send_valid, send_page, read_byte, dirty_mask,
        input  ready
    );
    modport sink (
        input  valid, send_valid, send_page, read_byte, dirty_mask,
        output ready
    );
endinterface

`default_nettype wire

/* design/fbdp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module fbdp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/fbdp_alu.sv */
// Byte combine unit: the one modify step of every read-modify-write on the store.
// Depends on fbdp_pkg for opcodes, combine modes and the control struct.
`default_nettype none

module fbdp_alu
    import fbdp_pkg::*;
(
    input  wire t_alu_ctl             i_ctl,
    input  wire logic [BYTE_BITS-1:0] i_old,
    output logic                      o_we,
    output logic      [BYTE_BITS-1:0] o_new
);

    logic [BYTE_BITS-1:0] bit_mask;

    assign bit_mask = BYTE_BITS'(1) << i_ctl.bit_sel;

    always_comb begin
        o_we  = 1'b1;
        o_new = i_old;
        case (i_ctl.opcode)
            OP_PIXEL_WRITE: begin
                o_new = i_ctl.pixel_on ? (i_old | bit_mask) : (i_old & ~bit_mask);
            end
            OP_PIXEL_INVERT: begin
                o_new = i_old ^ bit_mask;
            end
            OP_BYTE_COMBINE: begin
                case (i_ctl.mode)
                    CM_OR:    o_new = i_old | i_ctl.byte_value;
                    CM_WRITE: o_new = i_ctl.byte_value;
                    CM_AND:   o_new = i_old & i_ctl.byte_value;
                    CM_XOR:   o_new = i_old ^ i_ctl.byte_value;
                    default:  o_we  = 1'b0;
                endcase
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/framebuffer_dirty_page_engine_unit.sv */
// Page-organised monochrome frame store with dirty-page tracking. Each request gives
// one response. For pixel, byte combine and byte read requests the store is read in
// the cycle the request is taken; pixel and byte combine results are written back in
// the next, through the single shared combine unit. An update with the link free scans
// the dirty mask one page per cycle from the current scan position. A clear writes
// one byte per cycle through the store's only write port. After reset the same clearing
// pass runs over all SCREEN_WIDTH*PAGE_COUNT bytes (1024 by default) before the first
// request is taken. A response register lets the next request enter while a response
// waits.
`default_nettype none

module framebuffer_dirty_page_engine_unit
    import fbdp_pkg::*;
#(
    parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int unsigned PAGE_COUNT    = PAGE_COUNT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fbdp_req_if.sink   i_req,
    fbdp_rsp_if.source o_rsp
);

    localparam int unsigned DEPTH = SCREEN_WIDTH * PAGE_COUNT;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_CLEAR,
        S_HOLD
    } t_state;

    t_state                r_state;
    logic [AW-1:0]         r_clr_addr;
    logic [BYTE_BITS-1:0]  r_dirty;
    logic [PAGE_BITS-1:0]  r_scan_page;
    logic [PAGE_BITS:0]    r_scan_p;

    // Latched request.
    t_opcode               r_op;
    logic                  r_hit;
    logic [AW-1:0]         r_addr;
    logic [PAGE_BITS-1:0]  r_page;
    t_alu_ctl              r_ctl;

    // Pending response while the output register is occupied.
    logic                  r_res_send;
    logic [PAGE_BITS-1:0]  r_res_page;
    logic [BYTE_BITS-1:0]  r_res_byte;
    logic [BYTE_BITS-1:0]  r_res_mask;

    logic                  r_rsp_valid;
    logic                  r_rsp_send;
    logic [PAGE_BITS-1:0]  r_rsp_page;
    logic [BYTE_BITS-1:0]  r_rsp_byte;
    logic [BYTE_BITS-1:0]  r_rsp_mask;

    logic                  in_acc;
    logic                  pix_hit;
    logic                  byte_hit;
    logic                  in_hit;
    logic                  in_is_pixel;
    logic [PAGE_BITS-1:0]  in_page;
    logic [7:0]            in_col;
    logic [AW-1:0]         in_addr;
    logic                  slot_free;
    logic                  clearing;
    logic                  rsp_load;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [BYTE_BITS-1:0]  ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [BYTE_BITS-1:0]  ram_rdata;

    logic                  alu_we;
    logic [BYTE_BITS-1:0]  alu_new;

    logic                  fin;
    logic                  fin_send;
    logic [PAGE_BITS-1:0]  fin_page;
    logic [BYTE_BITS-1:0]  fin_byte;
    logic [BYTE_BITS-1:0]  n_dirty;
    logic [PAGE_BITS-1:0]  n_scan_page;

    // Request decode, done while the request is offered so the store read starts at once.
    assign in_acc      = i_req.valid && i_req.ready;
    assign in_is_pixel = (i_req.opcode == OP_PIXEL_WRITE) || (i_req.opcode == OP_PIXEL_INVERT);
    assign pix_hit     = (i_req.pos_x < 8'(SCREEN_WIDTH)) && (i_req.pos_y < 8'(SCREEN_HEIGHT))
                         && (i_req.pos_y[7:3] < 5'(PAGE_COUNT));
    assign byte_hit    = (i_req.column < 8'(SCREEN_WIDTH))
                         && (i_req.page_index < 8'(PAGE_COUNT));
    assign in_page     = in_is_pixel ? i_req.pos_y[5:3] : i_req.page_index[PAGE_BITS-1:0];
    assign in_col      = in_is_pixel ? i_req.pos_x : i_req.column;
    assign in_addr     = AW'(11'(in_page) * 11'(SCREEN_WIDTH) + 11'(in_col));

    always_comb begin
        case (i_req.opcode)
            OP_PIXEL_WRITE, OP_PIXEL_INVERT: in_hit = pix_hit;
            OP_BYTE_COMBINE, OP_READ_BYTE:   in_hit = byte_hit;
            default:                         in_hit = 1'b0;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign slot_free   = !r_rsp_valid || o_rsp.ready;
    assign clearing    = (r_state == S_INIT) || (r_state == S_CLEAR);
    assign rsp_load    = slot_free && (fin || (r_state == S_HOLD));

    fbdp_alu u_alu (
        .i_ctl (r_ctl),
        .i_old (ram_rdata),
        .o_we  (alu_we),
        .o_new (alu_new)
    );

    assign ram_we    = clearing || ((r_state == S_EXEC) && r_hit && alu_we);
    assign ram_waddr = clearing ? r_clr_addr : r_addr;
    assign ram_wdata = clearing ? '0 : alu_new;
    assign ram_raddr = (r_state == S_IDLE) ? in_addr : r_addr;

    fbdp_ram #(
        .WIDTH (BYTE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Completion of the current request and its effect on the page state.
    always_comb begin
        fin         = 1'b0;
        fin_send    = 1'b0;
        fin_page    = '0;
        fin_byte    = '0;
        n_dirty     = r_dirty;
        n_scan_page = r_scan_page;
        case (r_state)
            S_EXEC: begin
                fin = 1'b1;
                if (r_hit && (r_op != OP_READ_BYTE)) begin
                    n_dirty = r_dirty | (BYTE_BITS'(1) << r_page);
                end
                if (r_hit && (r_op == OP_READ_BYTE)) begin
                    fin_byte = ram_rdata;
                end
            end
            S_SCAN: begin
                if (r_scan_p >= (PAGE_BITS+1)'(PAGE_COUNT)) begin
                    fin         = 1'b1;
                    n_scan_page = '0;
                    n_dirty     = '0;
                end else if (r_dirty[r_scan_p[PAGE_BITS-1:0]]) begin
                    fin      = 1'b1;
                    fin_send = 1'b1;
                    fin_page = r_scan_p[PAGE_BITS-1:0];
                    if (r_scan_p == (PAGE_BITS+1)'(PAGE_COUNT - 1)) begin
                        n_scan_page = '0;
                        n_dirty     = '0;
                    end else begin
                        n_scan_page = r_scan_p[PAGE_BITS-1:0] + PAGE_BITS'(1);
                    end
                end
            end
            S_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    fin     = 1'b1;
                    n_dirty = ALL_PAGES;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr_addr  <= '0;
            r_dirty     <= '0;
            r_scan_page <= '0;
            r_scan_p    <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_dirty     <= n_dirty;
            r_scan_page <= n_scan_page;
            if (rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_op                 <= i_req.opcode;
                        r_hit                <= in_hit;
                        r_addr               <= in_addr;
                        r_page               <= in_page;
                        r_ctl.opcode         <= i_req.opcode;
                        r_ctl.bit_sel        <= i_req.pos_y[PAGE_BITS-1:0];
                        r_ctl.pixel_on       <= i_req.pixel_on;
                        r_ctl.byte_value     <= i_req.byte_value;
                        r_ctl.mode           <= i_req.combine_mode;
                        r_clr_addr           <= '0;
                        r_scan_p             <= {1'b0, r_scan_page};
                        case (i_req.opcode)
                            OP_UPDATE: r_state <= i_req.link_busy ? S_EXEC : S_SCAN;
                            OP_CLEAR:  r_state <= S_CLEAR;
                            default:   r_state <= S_EXEC;
                        endcase
                    end
                end
                S_EXEC: begin
                    // The request always completes here; the response logic below moves on.
                end
                S_SCAN: begin
                    r_scan_p <= r_scan_p + (PAGE_BITS+1)'(1);
                end
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
                S_HOLD: begin
                    if (slot_free) begin
                        r_rsp_send  <= r_res_send;
                        r_rsp_page  <= r_res_page;
                        r_rsp_byte  <= r_res_byte;
                        r_rsp_mask  <= r_res_mask;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (fin) begin
                if (slot_free) begin
                    r_rsp_send  <= fin_send;
                    r_rsp_page  <= fin_page;
                    r_rsp_byte  <= fin_byte;
                    r_rsp_mask  <= n_dirty;
                    r_state     <= S_IDLE;
                end else begin
                    r_res_send  <= fin_send;
                    r_res_page  <= fin_page;
                    r_res_byte  <= fin_byte;
                    r_res_mask  <= n_dirty;
                    r_state     <= S_HOLD;
                end
            end
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.send_valid = r_rsp_send;
    assign o_rsp.send_page  = r_rsp_page;
    assign o_rsp.read_byte  = r_rsp_byte;
    assign o_rsp.dirty_mask = r_rsp_mask;

`ifndef NO_ASSERTIONS
    // The scan position never points past the last page.
    a_scan_page_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_scan_page} < (PAGE_BITS+1)'(PAGE_COUNT))
        else $error("scan position beyond the last page");

    // Every cycle of a clearing pass writes a zero byte.
    a_clear_writes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (ram_we && (ram_wdata == '0)))
        else $error("clearing pass does not write zero");

    // A page offered for sending is a real page.
    a_send_page_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_rsp_send) |-> ({1'b0, r_rsp_page} < (PAGE_BITS+1)'(PAGE_COUNT)))
        else $error("sent page beyond the last page");

    // A finished clear leaves every page marked dirty.
    a_clear_marks_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && (r_state == S_CLEAR)) |=> (r_dirty == ALL_PAGES))
        else $error("clear did not mark all pages dirty");
`endif

endmodule

`default_nettype wire

/* dv/framebuffer_dirty_page_engine_unit_test.sv */
// Self-checking testbench for framebuffer_dirty_page_engine_unit: drives pixel, byte, update,
// read and clear requests with random pacing and checks every response against a frame model.
// Depends on fbdp_pkg and the fbdp_req_if / fbdp_rsp_if channel interfaces.
module framebuffer_dirty_page_engine_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fbdp_pkg::*;

    localparam int unsigned WIDTH  = SCREEN_WIDTH_DEF;
    localparam int unsigned HEIGHT = SCREEN_HEIGHT_DEF;
    localparam int unsigned PAGES  = PAGE_COUNT_DEF;

    // Opcodes the block must ignore, and combine modes that only mark the page dirty.
    localparam t_opcode OP_SPARE_LOW  = 3'd6;
    localparam t_opcode OP_SPARE_HIGH = 3'd7;
    localparam t_mode   CM_MARK_LOW   = 3'd4;
    localparam t_mode   CM_MARK_HIGH  = 3'd7;

    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE_CYCLES = 16;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       pixel_on;
        logic [7:0] column;
        logic [7:0] page_index;
        logic [7:0] byte_value;
        t_mode      combine_mode;
        logic       link_busy;
    } t_fb_request;

    typedef struct packed {
        logic       send_valid;
        logic [2:0] send_page;
        logic [7:0] read_byte;
        logic [7:0] dirty_mask;
    } t_fb_response;

    logic i_clk;
    logic i_rst_n;

    fbdp_req_if req ();
    fbdp_rsp_if rsp ();

    framebuffer_dirty_page_engine_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // Frame model state.
    logic [7:0]  frame_model [WIDTH*PAGES];
    logic [7:0]  dirty_model;
    int unsigned scan_model;

    t_fb_response pending_replies [$];
    int unsigned  mismatch_count;
    int unsigned  quiet_cycles;

    // Pacing controls shared with the response sink.
    bit sender_steady;
    bit sink_steady;
    bit hold_request;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_fb_response predict_frame_op(input t_fb_request r);
        t_fb_response res;
        int unsigned  row_page;
        int unsigned  idx;
        int unsigned  p;
        logic [7:0]   bit_mask;
        res = '0;
        case (r.opcode)
            OP_PIXEL_WRITE, OP_PIXEL_INVERT: begin
                row_page = r.pos_y >> 3;
                if (r.pos_x < WIDTH && r.pos_y < HEIGHT && row_page < PAGES) begin
                    idx = row_page * WIDTH + r.pos_x;
                    bit_mask = 8'd1 << r.pos_y[2:0];
                    dirty_model[row_page] = 1'b1;
                    if (r.opcode == OP_PIXEL_INVERT) begin
                        frame_model[idx] = frame_model[idx] ^ bit_mask;
                    end else if (r.pixel_on) begin
                        frame_model[idx] = frame_model[idx] | bit_mask;
                    end else begin
                        frame_model[idx] = frame_model[idx] & ~bit_mask;
                    end
                end
            end
            OP_BYTE_COMBINE: begin
                if (r.column < WIDTH && r.page_index < PAGES) begin
                    idx = r.page_index * WIDTH + r.column;
                    dirty_model[r.page_index] = 1'b1;
                    case (r.combine_mode)
                        CM_OR:    frame_model[idx] = frame_model[idx] | r.byte_value;
                        CM_WRITE: frame_model[idx] = r.byte_value;
                        CM_AND:   frame_model[idx] = frame_model[idx] & r.byte_value;
                        CM_XOR:   frame_model[idx] = frame_model[idx] ^ r.byte_value;
                        default: ;
                    endcase
                end
            end
            OP_UPDATE: begin
                if (!r.link_busy) begin
                    p = scan_model;
                    while (p < PAGES && !dirty_model[p]) p++;
                    if (p >= PAGES) begin
                        scan_model = 0;
                        dirty_model = '0;
                    end else begin
                        res.send_valid = 1'b1;
                        res.send_page = p[2:0];
                        // Sending the last page ends the sweep and forgets the mask.
                        if (p < PAGES - 1) begin
                            scan_model = p + 1;
                        end else begin
                            scan_model = 0;
                            dirty_model = '0;
                        end
                    end
                end
            end
            OP_READ_BYTE: begin
                if (r.column < WIDTH && r.page_index < PAGES) begin
                    res.read_byte = frame_model[r.page_index * WIDTH + r.column];
                end
            end
            OP_CLEAR: begin
                foreach (frame_model[i]) frame_model[i] = '0;
                dirty_model = ALL_PAGES;
            end
            default: ;
        endcase
        res.dirty_mask = dirty_model;
        return res;
    endfunction

    function automatic t_fb_request fb_req(input t_opcode op, input logic [7:0] x,
                                           input logic [7:0] y, input logic on,
                                           input logic [7:0] col, input logic [7:0] pg,
                                           input logic [7:0] data, input t_mode mode,
                                           input logic busy);
        t_fb_request r;
        r.opcode = op;
        r.pos_x = x;
        r.pos_y = y;
        r.pixel_on = on;
        r.column = col;
        r.page_index = pg;
        r.byte_value = data;
        r.combine_mode = mode;
        r.link_busy = busy;
        return r;
    endfunction

    // Columns favour a narrow strip so that reads often land on drawn bytes.
    function automatic logic [7:0] pick_column();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 8'($urandom_range(0, 255));
        if (roll < 6) return 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, WIDTH - 1));
    endfunction

    function automatic t_fb_request random_request();
        t_fb_request r;
        int unsigned roll;
        roll = $urandom_range(0, 199);
        if (roll < 60) r.opcode = OP_PIXEL_WRITE;
        else if (roll < 80) r.opcode = OP_PIXEL_INVERT;
        else if (roll < 130) r.opcode = OP_BYTE_COMBINE;
        else if (roll < 160) r.opcode = OP_UPDATE;
        else if (roll < 192) r.opcode = OP_READ_BYTE;
        else if (roll < 196) r.opcode = OP_CLEAR;
        else r.opcode = $urandom_range(0, 1) ? OP_SPARE_HIGH : OP_SPARE_LOW;
        r.pos_x = pick_column();
        r.pos_y = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, HEIGHT - 1));
        r.pixel_on = 1'($urandom_range(0, 1));
        r.column = pick_column();
        r.page_index = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, PAGES - 1));
        r.byte_value = 8'($urandom_range(0, 255));
        r.combine_mode = 3'($urandom_range(0, 7));
        r.link_busy = ($urandom_range(0, 3) == 0);
        return r;
    endfunction

    task automatic send_request(input t_fb_request r);
        int unsigned gap;
        gap = sender_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid        <= 1'b1;
        req.opcode       <= r.opcode;
        req.pos_x        <= r.pos_x;
        req.pos_y        <= r.pos_y;
        req.pixel_on     <= r.pixel_on;
        req.column       <= r.column;
        req.page_index   <= r.page_index;
        req.byte_value   <= r.byte_value;
        req.combine_mode <= r.combine_mode;
        req.link_busy    <= r.link_busy;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        pending_replies.push_back(predict_frame_op(r));
    endtask

    // Called at the edge a request was taken; always lets at least one edge pass.
    task automatic wait_for_replies();
        req.valid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    task automatic test_directed_cases();
        sender_steady = 1'b0;
        sink_steady = 1'b0;
        send_request(fb_req(OP_READ_BYTE, 0, 0, 0, 0, 0, 0, CM_OR, 0));
        send_request(fb_req(OP_PIXEL_WRITE, 0, 0, 1, 0, 0, 0, CM_OR, 0));
        send_request(fb_req(OP_PIXEL_WRITE, 127, 63, 1, 0, 0, 0, CM_OR, 0));
        send_request(fb_req(OP_PIXEL_WRITE, 128, 0, 1, 0, 0, 0, CM_OR, 0));
        send_request(fb_req(OP_PIXEL_WRITE, 0, 64, 1, 0, 0, 0, CM_OR, 0));
        send_request(fb_req(OP_PIXEL_WRITE, 255, 255, 1, 255, 255, 255, CM_MARK_HIGH, 1));
        send_request(fb_req(OP_PIXEL_INVERT, 0, 0, 0, 0, 0, 0, CM_OR, 0));
        send_request(fb_req(OP_PIXEL_INVERT, 127, 62, 0, 0, 0, 0, CM_OR, 0));
        send_request(fb_req(OP_PIXEL_WRITE, 127, 63, 0, 0, 0, 0, CM_OR, 0));
        send_request(fb_req(OP_BYTE_COMBINE, 0, 0, 0, 127, 7, 8'hA5, CM_WRITE, 0));
        send_request(fb_req(OP_BYTE_COMBINE, 0, 0, 0, 127, 7, 8'h5A, CM_OR, 0));
        send_request(fb_req(OP_BYTE_COMBINE, 0, 0, 0, 127, 7, 8'h0F, CM_AND, 0));
        send_request(fb_req(OP_BYTE_COMBINE, 0, 0, 0, 127, 7, 8'hFF, CM_XOR, 0));
        send_request(fb_req(OP_BYTE_COMBINE, 0, 0, 0, 0, 3, 8'hFF, CM_MARK_LOW, 0));
        send_request(fb_req(OP_BYTE_COMBINE, 0, 0, 0, 5, 5, 8'hFF, CM_MARK_HIGH, 0));
        send_request(fb_req(OP_BYTE_COMBINE, 0, 0, 0, 128, 0, 8'hFF, CM_WRITE, 0));
        send_request(fb_req(OP_BYTE_COMBINE, 0, 0, 0, 0, 8, 8'hFF, CM_WRITE, 0));
        send_request(fb_req(OP_READ_BYTE, 0, 0, 0, 127, 7, 0, CM_OR, 0));
        send_request(fb_req(OP_READ_BYTE, 0, 0, 0, 255, 255, 0, CM_OR, 0));
        send_request(fb_req(OP_UPDATE, 0, 0, 0, 0, 0, 0, CM_OR, 1));
        repeat (4) send_request(fb_req(OP_UPDATE, 0, 0, 0, 0, 0, 0, CM_OR, 0));
        send_request(fb_req(OP_SPARE_LOW, 5, 5, 1, 5, 5, 8'hFF, CM_WRITE, 0));
        send_request(fb_req(OP_SPARE_HIGH, 5, 5, 1, 5, 5, 8'hFF, CM_WRITE, 0));
        send_request(fb_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, CM_OR, 0));
        send_request(fb_req(OP_READ_BYTE, 0, 0, 0, 127, 7, 0, CM_OR, 0));
    endtask

    // The sink stops taking responses while the sender keeps pushing, so the block backs up.
    task automatic test_input_backpressure();
        sender_steady = 1'b1;
        hold_request = 1'b1;
        repeat (24) send_request(random_request());
        wait_for_replies();
        sender_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int seg = 0; seg < 13; seg++) begin
            sender_steady = ($urandom_range(0, 2) == 0);
            sink_steady = ($urandom_range(0, 2) == 0);
            repeat (50) send_request(random_request());
            if (seg == 6) wait_for_replies();
        end
        sender_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    // Response sink: random stalls per response, plus the long hold when asked.
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left = 0;
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp.valid && rsp.ready) stall_left = sink_steady ? 0 : $urandom_range(0, 13);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_fb_response want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (pending_replies.size() == 0) begin
                $error("response arrived with no request outstanding");
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                compare_field("send_valid", want.send_valid, rsp.send_valid);
                compare_field("send_page", want.send_page, rsp.send_page);
                compare_field("read_byte", want.read_byte, rsp.read_byte);
                compare_field("dirty_mask", want.dirty_mask, rsp.dirty_mask);
            end
        end
    end

    // Stall detector: the clearing pass and a clear under a long hold are the slowest gaps.
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("framebuffer_dirty_page_engine_unit test failed");
            $finish;
        end
    end

    initial begin
        mismatch_count = 0;
        quiet_cycles = 0;
        sender_steady = 1'b0;
        sink_steady = 1'b0;
        hold_request = 1'b0;
        foreach (frame_model[i]) frame_model[i] = '0;
        dirty_model = '0;
        scan_model = 0;
        i_rst_n          <= 1'b0;
        req.valid        <= 1'b0;
        req.opcode       <= OP_PIXEL_WRITE;
        req.pos_x        <= '0;
        req.pos_y        <= '0;
        req.pixel_on     <= 1'b0;
        req.column       <= '0;
        req.page_index   <= '0;
        req.byte_value   <= '0;
        req.combine_mode <= CM_OR;
        req.link_busy    <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_input_backpressure();
        test_random_traffic();

        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_replies.size() == 0) begin
            $display("framebuffer_dirty_page_engine_unit test passed");
        end else begin
            $display("framebuffer_dirty_page_engine_unit test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
design/fbdp_pkg.sv
design/fbdp_if.sv
design/fbdp_ram.sv
design/fbdp_alu.sv
design/framebuffer_dirty_page_engine_unit.sv
dv/framebuffer_dirty_page_engine_unit_test.sv
